/* src/mvm_pkg.sv */
`default_nettype none

package mvm_pkg;

   // Fixed field widths of the request and response items.
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int SIZE_W     = 7;
   localparam int DOT_W      = 38;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - ROW_W - DOT_W;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      KIND_MATRIX = 2'd0,
      KIND_VECTOR = 2'd1,
      KIND_RUN    = 2'd2
   } kind_type;

   // Control that travels with each issued store read.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_col;
      logic             last_row;
      logic [ROW_W-1:0] row;
   } mac_ctl_type;

   typedef struct packed {
      logic                    last;
      logic [ROW_W-1:0]        row;
      logic signed [DOT_W-1:0] dot;
   } result_type;

endpackage

`default_nettype wire

/* src/mvm_ram.sv */
`default_nettype none

module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* src/mvm_mac.sv */
`default_nettype none

module mvm_mac #(
   parameter int ELEM_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mvm_pkg::mac_ctl_type        issue_ctl,
   input  wire logic signed [ELEM_BITS-1:0] mat_q,
   input  wire logic signed [ELEM_BITS-1:0] vec_q,
   output logic                             res_valid,
   output mvm_pkg::result_type              res
);

   mvm_pkg::mac_ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic signed [2*ELEM_BITS-1:0]     prod_ff;
   logic signed [mvm_pkg::DOT_W-1:0]  acc_ff, acc_in;

   // The first column of a row restarts the sum instead of adding to it.
   always_comb begin
      acc_in = (ctl2_ff.first ? '0 : acc_ff) + mvm_pkg::DOT_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= issue_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mat_q * vec_q;
      if (ctl2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign res_valid = ctl3_ff.valid && ctl3_ff.last_col;
   assign res.last  = ctl3_ff.last_row;
   assign res.row   = ctl3_ff.row;
   assign res.dot   = acc_ff;

endmodule

`default_nettype wire

/* src/matrix_vector_multiply_top.sv */
// Channel   Direction  Payload
// req       in         tuser: kind; tdata: row, col, value, zero fill
// rsp       out        tdata: row_index, dot_product, zero fill; tlast: last
// csr       in         csr_wdata: matrix_size, written when csr_we is high
//
// A matrix or vector load is written while idle. A run reads each matrix element
// once, one read per cycle unless a row start is held back, before the next
// request is accepted; at size three the third row waits for the first row's
// result to leave. Results pass read, product, accumulator and output registers.
// At most two rows may be started and not yet delivered, so a stalled response
// side holds back the start of further rows. Reset clears control state only;
// both memories are undefined until written and get no clearing pass.
`default_nettype none

module matrix_vector_multiply_top #(
   parameter int MAX_N     = 64,
   parameter int ELEM_BITS = 16,
   localparam int REQ_DATA_W =
      ((mvm_pkg::ROW_W + mvm_pkg::COL_W + ELEM_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]             req_tdata,  // row, col, value
   input  wire logic [1:0]                        req_tuser,  // kind
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [mvm_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // row_index, dot_product
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [mvm_pkg::SIZE_W-1:0]        csr_wdata
);

   localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                      state_ff;
   logic [IDX_W-1:0]               row_ff, col_ff, last_ff, last_in;
   logic [mvm_pkg::SIZE_W-1:0]     size_ff, size_eff;
   logic [1:0]                     outstanding_ff, outstanding_in;

   mvm_pkg::kind_type              req_kind;
   logic [mvm_pkg::ROW_W-1:0]      req_row;
   logic [mvm_pkg::COL_W-1:0]      req_col;
   logic [ELEM_BITS-1:0]           req_value;
   logic                           accept, row_ok, col_ok, mat_we, vec_we;
   logic                           credit_ok, issue, row_start, pop;

   mvm_pkg::mac_ctl_type           issue_ctl;
   logic [ELEM_BITS-1:0]           mat_q, vec_q;
   logic                           res_valid;
   mvm_pkg::result_type            res;

   logic                           out_valid_ff, out_valid_in;
   logic                           spare_valid_ff, spare_valid_in;
   mvm_pkg::result_type            out_ff, out_in, spare_ff, spare_in;

   assign req_kind  = mvm_pkg::kind_type'(req_tuser);
   assign req_row   = req_tdata[mvm_pkg::ROW_W-1:0];
   assign req_col   = req_tdata[mvm_pkg::ROW_W +: mvm_pkg::COL_W];
   assign req_value = req_tdata[mvm_pkg::ROW_W + mvm_pkg::COL_W +: ELEM_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign row_ok     = {1'b0, req_row} < mvm_pkg::SIZE_W'(MAX_N);
   assign col_ok     = {1'b0, req_col} < mvm_pkg::SIZE_W'(MAX_N);
   assign mat_we     = accept && (req_kind == mvm_pkg::KIND_MATRIX) && row_ok && col_ok;
   assign vec_we     = accept && (req_kind == mvm_pkg::KIND_VECTOR) && col_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mvm_pkg::SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   // A size of zero runs as one row; anything above the store runs as the full store.
   always_comb begin
      if (size_ff == '0) begin
         size_eff = mvm_pkg::SIZE_W'(1);
      end else if (size_ff > mvm_pkg::SIZE_W'(MAX_N)) begin
         size_eff = mvm_pkg::SIZE_W'(MAX_N);
      end else begin
         size_eff = size_ff;
      end
      last_in = IDX_W'(size_eff - mvm_pkg::SIZE_W'(1));
   end

   // A new row starts only while fewer than two rows are waiting for delivery.
   assign credit_ok = (outstanding_ff < 2'd2);
   assign issue     = (state_ff == ST_RUN) && ((col_ff != '0) || credit_ok);
   assign row_start = issue && (col_ff == '0);
   assign pop       = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         last_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_kind == mvm_pkg::KIND_RUN)) begin
                  state_ff <= ST_RUN;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  last_ff  <= last_in;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  if (col_ff == last_ff) begin
                     col_ff <= '0;
                     if (row_ff == last_ff) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        row_ff <= row_ff + 1'b1;
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      issue_ctl.valid    = issue;
      issue_ctl.first    = (col_ff == '0);
      issue_ctl.last_col = (col_ff == last_ff);
      issue_ctl.last_row = (row_ff == last_ff);
      issue_ctl.row      = mvm_pkg::ROW_W'(row_ff);
   end

   mvm_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (2 ** (2 * IDX_W))
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr ({req_row[IDX_W-1:0], req_col[IDX_W-1:0]}),
      .wr_data (req_value),
      .rd_addr ({row_ff, col_ff}),
      .rd_data (mat_q)
   );

   mvm_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (2 ** IDX_W)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (req_col[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (col_ff),
      .rd_data (vec_q)
   );

   mvm_mac #(
      .ELEM_BITS (ELEM_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue_ctl (issue_ctl),
      .mat_q     (mat_q),
      .vec_q     (vec_q),
      .res_valid (res_valid),
      .res       (res)
   );

   // Two-entry response buffer: the spare entry fills only while the output is held.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      spare_valid_in = spare_valid_ff;
      spare_in       = spare_ff;
      if (pop) begin
         out_valid_in   = spare_valid_ff;
         out_in         = spare_ff;
         spare_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            spare_valid_in = 1'b1;
            spare_in       = res;
         end
      end
      outstanding_in = 2'(outstanding_ff + {1'b0, row_start} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
         outstanding_ff <= '0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
         outstanding_ff <= outstanding_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{mvm_pkg::RSP_PAD_W{1'b0}}, out_ff.dot, out_ff.row};
   assign rsp_tlast  = out_ff.last;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 2'd2)
      else $error("more than two rows started and not delivered");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && spare_valid_ff))
      else $error("row result arrived with the response buffer full");

   a_spare_order: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> out_valid_ff)
      else $error("spare entry held while the output register is empty");

endmodule

`default_nettype wire
